// ----- src/softmax_argmax_classifier_top_defines.svh -----
// assertion macros for the softmax argmax classifier
// used by the checker module only
`ifndef SOFTMAX_ARGMAX_CLASSIFIER_TOP_DEFINES_SVH
`define SOFTMAX_ARGMAX_CLASSIFIER_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SAC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define SAC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/sac_pkg.sv -----
// shared types, constants and exp table for the softmax argmax classifier
// no dependencies
`timescale 1ns / 1ps
package sac_pkg;
  localparam int unsigned MaxLogitsDef = 8;
  localparam logic [3:0] NumLogitsRst = 4'd6;
  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RD, ST_SUB, ST_MUL, ST_EXP, ST_DIVINIT, ST_DIVRD, ST_DIVRUN,
    ST_DIVWB, ST_EMRD, ST_EMIT
  } sac_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // store accepted logit
    logic clr;      // reset running max and sum
    logic sub;      // form max - logit
    logic mul;      // multiply by log2(e)
    logic expw;     // finish exp, write exp store, accumulate
    logic divinit;  // start division
    logic divstep;  // one quotient bit
    logic divwb;    // write probability, update best
    logic emit;     // load result payload for output
    logic [5:0] idx;
  } sac_cmd_t;

  typedef struct packed {
    logic div_done;
  } sac_sts_t;

  // round(65536 * 2^(-j/16))
  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] t;
    unique case (j)
      5'd0: t = 17'd65536;  5'd1: t = 17'd62757;  5'd2: t = 17'd60097;
      5'd3: t = 17'd57549;  5'd4: t = 17'd55109;  5'd5: t = 17'd52773;
      5'd6: t = 17'd50535;  5'd7: t = 17'd48393;  5'd8: t = 17'd46341;
      5'd9: t = 17'd44376;  5'd10: t = 17'd42495; 5'd11: t = 17'd40693;
      5'd12: t = 17'd38968; 5'd13: t = 17'd37316; 5'd14: t = 17'd35734;
      5'd15: t = 17'd34219; default: t = 17'd32768;
    endcase
    return t;
  endfunction
endpackage

// ----- src/sac_ram.sv -----
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
module sac_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- src/sac_datapath.sv -----
// datapath: logit store, exp unit, sum, serial divider, best tracking
// depends on sac_pkg and sac_ram
`timescale 1ns / 1ps
module sac_datapath #(
  parameter int unsigned MAX_LOGITS = sac_pkg::MaxLogitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sac_pkg::sac_cmd_t cmd,
  output sac_pkg::sac_sts_t sts,
  input  logic [15:0]       in_logit,
  output logic [15:0]       prob,
  output logic [2:0]        best_idx,
  output logic [15:0]       best_p
);
  import sac_pkg::*;
  localparam int unsigned AW = $clog2(MAX_LOGITS);

  logic signed [15:0] max_r, max_nxt;
  logic [19:0] sum_r;
  logic [15:0] lrd, erd, prd;
  logic [16:0] x_r;
  logic [33:0] y_r;
  logic [15:0] e_w;
  logic [36:0] rem_r;
  logic [15:0] q_r;
  logic [4:0]  bit_r;
  logic [2:0]  best_idx_r;
  logic [15:0] best_p_r;
  logic [15:0] prob_r;
  logic [2:0]  obest_idx_r;
  logic [15:0] obest_p_r;
  logic [AW-1:0] a;

  assign a = cmd.idx[AW-1:0];

  sac_ram #(.WIDTH(16), .DEPTH(MAX_LOGITS)) u_lram (
    .clk, .we(cmd.load), .waddr(a), .wdata(in_logit), .raddr(a), .rdata(lrd));
  sac_ram #(.WIDTH(16), .DEPTH(MAX_LOGITS)) u_eram (
    .clk, .we(cmd.expw), .waddr(a), .wdata(e_w), .raddr(a), .rdata(erd));
  sac_ram #(.WIDTH(16), .DEPTH(MAX_LOGITS)) u_pram (
    .clk, .we(cmd.divwb), .waddr(a), .wdata(q_r), .raddr(a), .rdata(prd));

  // running max
  always_comb begin
    max_nxt = max_r;
    if (cmd.clr) max_nxt = 16'sh8000;
    else if (cmd.load && $signed(in_logit) > max_r) max_nxt = $signed(in_logit);
  end

  // exp tail: table interpolation and shift by k
  logic [9:0]  k_w;
  logic [4:0]  j_w;
  logic [11:0] r_w;
  logic [16:0] hi_w, lo_w, v_w, d_w;
  logic [28:0] ip_w;
  logic [17:0] rs_w;
  always_comb begin
    k_w  = y_r[33:24];
    j_w  = {1'b0, y_r[23:20]};
    r_w  = y_r[19:8];
    hi_w = pow2_tab(j_w);
    lo_w = pow2_tab(j_w + 5'd1);
    d_w  = hi_w - lo_w;
    ip_w = d_w * r_w + 29'd2048;
    v_w  = hi_w - 17'(ip_w >> 12);
    if (k_w > 10'd16) rs_w = '0;
    else if (k_w == 10'd0) rs_w = {1'b0, v_w};
    else rs_w = ({1'b0, v_w} + (18'd1 << (k_w[4:0] - 5'd1))) >> k_w[4:0];
    e_w = (rs_w > 18'd65535) ? 16'hFFFF : rs_w[15:0];
  end

  // divider: restoring, one quotient bit per cycle, 17 bits then saturate
  logic [36:0] dsh;
  assign dsh = {17'd0, sum_r} << bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= 16'sh8000;
      sum_r <= '0;
      best_idx_r <= '0;
      best_p_r <= '0;
    end else begin
      max_r <= max_nxt;
      if (cmd.clr) sum_r <= '0;
      else if (cmd.expw) sum_r <= sum_r + {4'd0, e_w};
      if (cmd.divwb && (cmd.idx == '0 || q_r > best_p_r)) begin
        best_p_r <= q_r;
        best_idx_r <= cmd.idx[2:0];
      end
    end
  end

  // payload registers of the exp and divide pipeline
  always_ff @(posedge clk) begin
    if (cmd.sub) x_r <= 17'($signed({max_r[15], max_r}) - $signed({lrd[15], lrd}));
    if (cmd.mul) y_r <= x_r * Log2eQ16;
    if (cmd.divinit) begin
      rem_r <= {5'd0, erd, 16'd0} + {17'd0, 1'b0, sum_r[19:1]};
      q_r   <= '0;
      bit_r <= 5'd16;
    end else if (cmd.divstep) begin
      if (rem_r >= dsh) begin
        rem_r <= rem_r - dsh;
        if (bit_r == 5'd16) q_r <= 16'hFFFF;
        else if (q_r != 16'hFFFF || bit_r == 5'd15) q_r <= q_r | (16'd1 << bit_r[3:0]);
      end
      bit_r <= bit_r - 5'd1;
    end
  end

  // result payload, held until the next result is issued
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      prob_r      <= prd;
      obest_idx_r <= best_idx_r;
      obest_p_r   <= best_p_r;
    end
  end

  assign sts.div_done = (bit_r == 5'd0) && cmd.divstep;
  assign prob = prob_r;
  assign best_idx = obest_idx_r;
  assign best_p = obest_p_r;
endmodule

// ----- src/sac_ctrl.sv -----
// controller: load, exp pass, divide pass and emit sequencing
// depends on sac_pkg
`timescale 1ns / 1ps
module sac_ctrl #(
  parameter int unsigned MAX_LOGITS = sac_pkg::MaxLogitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data,
  output sac_pkg::sac_cmd_t cmd,
  input  sac_pkg::sac_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_idx,
  output logic              out_last
);
  import sac_pkg::*;
  localparam logic [6:0] MaxL = 7'(MAX_LOGITS);

  sac_state_t st_r, st_nxt;
  logic [3:0] nl_r;
  logic [5:0] fill_r, fill_nxt, idx_r, idx_nxt, len_r, len_nxt;
  logic       ov_r, ov_nxt;
  logic [2:0] oi_r, oi_nxt;
  logic       ol_r, ol_nxt;
  logic [6:0] eff;

  // effective vector length
  always_comb begin
    if (nl_r < 4'd2) eff = 7'd2;
    else if ({3'd0, nl_r} > MaxL) eff = MaxL;
    else eff = {3'd0, nl_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD; nl_r <= NumLogitsRst; fill_r <= '0; idx_r <= '0;
      len_r <= '0; ov_r <= 1'b0; oi_r <= '0; ol_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; idx_r <= idx_nxt; len_r <= len_nxt;
      ov_r <= ov_nxt; oi_r <= oi_nxt; ol_r <= ol_nxt;
      if (cfg_we) nl_r <= cfg_data;
    end
  end

  // next state and commands
  always_comb begin
    st_nxt = st_r; fill_nxt = fill_r; idx_nxt = idx_r; len_nxt = len_r;
    ov_nxt = ov_r; oi_nxt = oi_r; ol_nxt = ol_r;
    cmd = '0;
    cmd.idx = idx_r;
    in_stall = 1'b1;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      ST_LOAD: begin
        // the last result of a vector must leave before new logits come in
        in_stall = ov_r;
        cmd.idx = fill_r;
        if (in_valid && !ov_r) begin
          cmd.load = 1'b1;
          if ({1'b0, fill_r} + 7'd1 >= eff) begin
            len_nxt = fill_r + 6'd1; fill_nxt = '0; idx_nxt = '0;
            st_nxt = ST_RD;
          end else fill_nxt = fill_r + 6'd1;
        end
      end
      ST_RD: st_nxt = ST_SUB;
      ST_SUB: begin cmd.sub = 1'b1; st_nxt = ST_MUL; end
      ST_MUL: begin cmd.mul = 1'b1; st_nxt = ST_EXP; end
      ST_EXP: begin
        cmd.expw = 1'b1;
        if (idx_r + 6'd1 == len_r) begin idx_nxt = '0; st_nxt = ST_DIVRD; end
        else begin idx_nxt = idx_r + 6'd1; st_nxt = ST_RD; end
      end
      ST_DIVRD: st_nxt = ST_DIVINIT;
      ST_DIVINIT: begin cmd.divinit = 1'b1; st_nxt = ST_DIVRUN; end
      ST_DIVRUN: begin
        cmd.divstep = 1'b1;
        if (sts.div_done) st_nxt = ST_DIVWB;
      end
      ST_DIVWB: begin
        cmd.divwb = 1'b1;
        if (idx_r + 6'd1 == len_r) begin idx_nxt = '0; st_nxt = ST_EMRD; end
        else begin idx_nxt = idx_r + 6'd1; st_nxt = ST_DIVRD; end
      end
      ST_EMRD: begin
        if (!ov_r || !out_stall) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        ov_nxt = 1'b1; oi_nxt = idx_r[2:0];
        ol_nxt = (idx_r + 6'd1 == len_r);
        if (idx_r + 6'd1 == len_r) begin
          idx_nxt = '0; cmd.clr = 1'b1; st_nxt = ST_LOAD;
        end else begin idx_nxt = idx_r + 6'd1; st_nxt = ST_EMRD; end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  assign out_valid = ov_r;
  assign out_idx = oi_r;
  assign out_last = ol_r;
endmodule

// ----- src/softmax_argmax_classifier_top.sv -----
// Softmax with argmax over up to MAX_LOGITS signed Q8.8 logits. Logits are
// taken one per cycle while in_stall is low, until num_logits (clamped to
// 2..MAX_LOGITS) have arrived; then the controller runs one exp pass (read,
// subtract, multiply and exp steps per element through a shared exp unit) and
// one divide pass (restoring divider, one bit per cycle), then emits one result
// per element. No new logit is taken until the last result has left. depends on
// sac_pkg, sac_ctrl, sac_datapath.
`timescale 1ns / 1ps
module softmax_argmax_classifier_top #(
  parameter int unsigned MAX_LOGITS = sac_pkg::MaxLogitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_num_logits,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_logit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_element_index,
  output logic [15:0] out_probability,
  output logic [2:0]  out_best_index,
  output logic [15:0] out_best_confidence,
  output logic        out_last
);
  import sac_pkg::*;
  sac_cmd_t cmd;
  sac_sts_t sts;

  sac_ctrl #(.MAX_LOGITS(MAX_LOGITS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .cfg_we, .cfg_data(cfg_num_logits),
    .cmd, .sts, .out_valid, .out_stall, .out_idx(out_element_index), .out_last);

  sac_datapath #(.MAX_LOGITS(MAX_LOGITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_logit, .prob(out_probability),
    .best_idx(out_best_index), .best_p(out_best_confidence));
endmodule

// ----- src/sac_checker.sv -----
// port-level checker for the softmax argmax classifier
// depends on the defines header
`timescale 1ns / 1ps
`include "softmax_argmax_classifier_top_defines.svh"
module sac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_element_index,
  input logic [15:0] out_probability,
  input logic        out_last
);
  `SAC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_probability) && $stable(out_element_index), "result changed while stalled")
  `SAC_ASSERT_IMP(a_no_in_while_out, out_valid, in_stall, "input taken while results pending")
  `SAC_ASSERT_NXT(a_last_then_zero, out_valid && !out_stall && out_last, !out_valid, "extra result after last")
endmodule

bind softmax_argmax_classifier_top sac_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_element_index, .out_probability, .out_last);

// ----- test/tb.sv -----
// self-checking bench for softmax_argmax_classifier_top: logit items in, per-element
// probability items out, checked against an in-bench fixed-point softmax predictor
// depends on sac_pkg and softmax_argmax_classifier_top
`timescale 1ns / 1ps

// expected or observed result item
typedef struct {
  logic [2:0]  elem;
  logic [15:0] prob;
  logic [2:0]  best;
  logic [15:0] conf;
  logic        last;
} prob_item_t;

// softmax predictor plus queue of pending probability items
class softmax_scoreboard;
  logic [3:0]  len_reg;
  logic [15:0] logits [8];
  int unsigned fill;
  int          vec_max;
  prob_item_t  pending_q [$];
  int          errors;

  // round(65536 * 2^(-j/16)), j = 0..16
  int unsigned pow2_frac [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
    48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  function new();
    len_reg = sac_pkg::NumLogitsRst;
    fill    = 0;
    vec_max = -32768;
    errors  = 0;
  endfunction

  // exp(-x) for x in Q8.8, result Q0.16
  function int unsigned exp_neg(int unsigned x);
    longint unsigned y;
    int unsigned k, f, j, r, hi, lo, v, e;
    y  = longint'(x) * 94548;
    k  = 32'(y >> 24);
    f  = 32'((y >> 8) & 16'hffff);
    j  = f >> 12;
    r  = f & 12'hfff;
    hi = pow2_frac[j];
    lo = pow2_frac[j + 1];
    v  = hi - (((hi - lo) * r + 2048) >> 12);
    if (k > 16) return 0;
    e = (k == 0) ? v : ((v + (1 << (k - 1))) >> k);
    return (e > 65535) ? 65535 : e;
  endfunction

  // note one accepted logit; a completed vector queues its items
  function void note_logit(logic [15:0] raw);
    int unsigned eff, n, sum, best, bestp;
    int unsigned ex [8];
    int unsigned pr [8];
    longint unsigned p;
    prob_item_t it;
    eff = (len_reg < 2) ? 2 : ((len_reg > 8) ? 8 : len_reg);
    if (fill > 7) fill = 7;
    logits[fill] = raw;
    if ($signed(raw) > vec_max) vec_max = $signed(raw);
    fill++;
    if (fill < eff) return;
    n   = fill;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      ex[i] = exp_neg(vec_max - int'($signed(logits[i])));
      sum += ex[i];
    end
    best  = 0;
    bestp = 0;
    for (int i = 0; i < n; i++) begin
      p = (longint'(ex[i]) * 65536 + (sum >> 1)) / sum;
      pr[i] = (p > 65535) ? 65535 : 32'(p);
      if (i == 0 || pr[i] > bestp) begin
        bestp = pr[i];
        best  = i;
      end
    end
    for (int i = 0; i < n; i++) begin
      it.elem = 3'(i);
      it.prob = 16'(pr[i]);
      it.best = 3'(best);
      it.conf = 16'(bestp);
      it.last = (i + 1 == n);
      pending_q = {pending_q, it};
    end
    fill    = 0;
    vec_max = -32768;
  endfunction

  // compare one accepted result item with the oldest expectation
  function void check_item(prob_item_t got);
    prob_item_t exp_it;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected item elem=%0d prob=%0d", $time, got.elem, got.prob);
      errors++;
      return;
    end
    exp_it = pending_q.pop_front();
    if (got.elem !== exp_it.elem) begin
      $display("%0t: element_index exp %0d got %0d", $time, exp_it.elem, got.elem);
      errors++;
    end
    if (got.prob !== exp_it.prob) begin
      $display("%0t: probability exp %0d got %0d", $time, exp_it.prob, got.prob);
      errors++;
    end
    if (got.best !== exp_it.best) begin
      $display("%0t: best_index exp %0d got %0d", $time, exp_it.best, got.best);
      errors++;
    end
    if (got.conf !== exp_it.conf) begin
      $display("%0t: best_confidence exp %0d got %0d", $time, exp_it.conf, got.conf);
      errors++;
    end
    if (got.last !== exp_it.last) begin
      $display("%0t: last exp %0d got %0d", $time, exp_it.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int StallLimit = 6000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_num_logits;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_logit;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_element_index;
  logic [15:0] out_probability;
  logic [2:0]  out_best_index;
  logic [15:0] out_best_confidence;
  logic        out_last;

  softmax_scoreboard softmax_sb;
  bit quiet;
  int idle_cycles = 0;

  softmax_argmax_classifier_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_num_logits      (cfg_num_logits),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_logit            (in_logit),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_element_index   (out_element_index),
    .out_probability     (out_probability),
    .out_best_index      (out_best_index),
    .out_best_confidence (out_best_confidence),
    .out_last            (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // accepted items on both channels, plus no-progress watchdog
  always @(posedge clk) begin
    prob_item_t got;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        softmax_sb.note_logit(in_logit);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.elem = out_element_index;
        got.prob = out_probability;
        got.best = out_best_index;
        got.conf = out_best_confidence;
        got.last = out_last;
        softmax_sb.check_item(got);
        moved = 1'b1;
      end
      if (moved) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // result-side stall bursts, off in the quiet tail
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 60)) @(negedge clk);
      end
    end
  end

  // drive one logit item, with an optional idle burst before it
  task automatic send_logit(input logic [15:0] value);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_logit = value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every expected item has arrived and the block has settled
  task automatic wait_drained();
    in_valid = 1'b0;
    while (softmax_sb.pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // length register write, only when drained
  task automatic write_len(input logic [3:0] len);
    wait_drained();
    cfg_we         = 1'b1;
    cfg_num_logits = len;
    @(negedge clk);
    cfg_we = 1'b0;
    softmax_sb.len_reg = len;
  endtask

  // random logit: full range, clustered, or a repeat of a base
  function automatic logic [15:0] rand_logit(input int base);
    unique case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(base + int'($urandom_range(0, 4095)) - 2048);
      2: return 16'(base + int'($urandom_range(0, 255)) - 128);
      default: return 16'(base);
    endcase
  endfunction

  initial begin
    logic [3:0] lens [$];
    int base;
    int count;
    softmax_sb     = new();
    quiet          = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_num_logits = 4'd0;
    in_valid       = 1'b0;
    in_logit       = 16'd0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset length of six: all ties, extremes, far-below elements, tie away from zero
    repeat (6) send_logit(16'h0000);
    send_logit(16'h7fff);
    send_logit(16'h8000);
    send_logit(16'h0001);
    send_logit(16'hffff);
    send_logit(16'h7ffe);
    send_logit(16'h8000);
    send_logit(16'h0100);
    send_logit(16'h0300);
    send_logit(16'h1200);
    send_logit(16'h0000);
    send_logit(16'h1200);
    send_logit(16'h5555);
    // shortest length with both extremes
    write_len(4'd2);
    send_logit(16'h8000);
    send_logit(16'h7fff);
    // length lowered mid-vector: three logits in, then length one completes on next
    write_len(4'd8);
    send_logit(16'h0400);
    send_logit(16'haaaa);
    send_logit(16'h0400);
    write_len(4'd1);
    send_logit(16'h0401);
    wait_drained();

    // random phases, each with a new length setting
    lens = '{4'd8, 4'd0, 4'd15, 4'd2, 4'd9, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd1,
             4'd10, 4'd11, 4'd12, 4'd13, 4'd14};
    count = 0;
    while (count < 500) begin
      logic [3:0] len;
      int n;
      len = (lens.size() != 0) ? lens.pop_front() : 4'($urandom_range(0, 15));
      if (count > 440) quiet = 1'b1;
      write_len(len);
      base = $urandom_range(0, 65535) - 32768;
      n = $urandom_range(4, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) base = $urandom_range(0, 65535) - 32768;
        send_logit(rand_logit(base));
      end
      count += n;
    end

    wait_drained();
    if (softmax_sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+src
src/sac_pkg.sv
src/sac_ram.sv
src/sac_datapath.sv
src/sac_ctrl.sv
src/softmax_argmax_classifier_top.sv
src/sac_checker.sv
test/tb.sv
